[src/sptq_pkg.sv]
`default_nettype none

package sptq_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_LEVEL = 2'd3
  } status_e;

  // request function codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic issue;   // request taken: latch it, launch memory reads
    logic commit;  // read data back: update lists, load result
  } ctrl_cmd_t;

endpackage

`default_nettype wire

[src/sptq_ram.sv]
`default_nettype none

module sptq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/sptq_ctrl.sv]
`default_nettype none

module sptq_ctrl
  import sptq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  output logic      done_o,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign cmd_o.issue  = start_i && (state_q == S_IDLE);
  assign cmd_o.commit = (state_q == S_COMMIT);

  a_issue_to_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |=> (state_q == S_COMMIT) && !done_q)
    else $error("request not followed by commit");

  a_commit_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> done_q && (state_q == S_IDLE))
    else $error("commit not followed by result strobe");

endmodule

`default_nettype wire

[src/sptq_dp.sv]
`default_nettype none

module sptq_dp
  import sptq_pkg::*;
#(
  parameter int LEVELS       = 8,
  parameter int POOL_ENTRIES = 64,
  parameter int TAG_BITS     = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_cmd_t   cmd_i,
  input  wire logic        func_i,
  input  wire logic [2:0]  priority_req_i,
  input  wire logic [31:0] task_tag_i,
  output logic      [1:0]  status_o,
  output logic      [2:0]  popped_level_o,
  output logic      [31:0] popped_tag_o,
  output logic             tasks_pending_o
);

  localparam int LW = $clog2(LEVELS);
  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int TW = (TAG_BITS < 32) ? TAG_BITS : 32;

  // list state
  logic [PW-1:0]     head_q [LEVELS];
  logic [PW-1:0]     head_d [LEVELS];
  logic [PW-1:0]     tail_q [LEVELS];
  logic [PW-1:0]     tail_d [LEVELS];
  logic [LEVELS-1:0] nonempty_q, nonempty_d;
  logic [CW-1:0]     free_count_q, free_count_d;
  // lowest free stack depth ever reached; slots below it stand for their own index
  logic [CW-1:0]     low_q, low_d;

  // latched request
  logic          op_push_ok_q, op_pop_ok_q, op_fresh_q, op_last_q;
  status_e       op_status_q;
  logic [LW-1:0] op_lvl_q;
  logic [TW-1:0] op_tag_q;
  logic [PW-1:0] op_entry_q;

  // result
  logic [1:0]  status_q;
  logic [2:0]  popped_level_q;
  logic [31:0] popped_tag_q;
  logic        pending_q;

  // issue side
  logic          is_push, lvl_ok, push_ok_in, pop_ok_in;
  logic [LW-1:0] in_lvl, pop_lvl;
  logic [PW-1:0] fs_top;
  status_e       status_in;

  // memories
  logic [TW-1:0] tag_rdata;
  logic [PW-1:0] link_rdata, fs_rdata;
  logic          tag_we, link_we, fs_we;
  logic [PW-1:0] link_waddr, fs_waddr, alloc_e;

  assign is_push = (func_i == FUNC_PUSH);
  assign in_lvl  = LW'(priority_req_i);
  assign lvl_ok  = (int'(priority_req_i) < LEVELS);
  assign fs_top  = PW'(free_count_q - CW'(1));

  assign push_ok_in = is_push && lvl_ok && (free_count_q != '0);
  assign pop_ok_in  = !is_push && (nonempty_q != '0);

  always_comb begin
    pop_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i]) begin
        pop_lvl = LW'(i);
      end
    end
  end

  always_comb begin
    priority if (is_push && !lvl_ok) begin
      status_in = ST_BAD_LEVEL;
    end else if (is_push && (free_count_q == '0)) begin
      status_in = ST_FULL;
    end else if (!is_push && (nonempty_q == '0)) begin
      status_in = ST_EMPTY;
    end else begin
      status_in = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      op_push_ok_q <= push_ok_in;
      op_pop_ok_q  <= pop_ok_in;
      op_status_q  <= status_in;
      op_lvl_q     <= is_push ? in_lvl : pop_lvl;
      op_tag_q     <= task_tag_i[TW-1:0];
      op_fresh_q   <= (free_count_q == low_q);
      op_entry_q   <= is_push ? fs_top : head_q[pop_lvl];
      op_last_q    <= (head_q[pop_lvl] == tail_q[pop_lvl]);
    end
  end

  // commit side
  assign alloc_e    = op_fresh_q ? op_entry_q : fs_rdata;
  assign tag_we     = cmd_i.commit && op_push_ok_q;
  assign link_we    = cmd_i.commit && op_push_ok_q && nonempty_q[op_lvl_q];
  assign link_waddr = tail_q[op_lvl_q];
  assign fs_we      = cmd_i.commit && op_pop_ok_q && (free_count_q < CW'(POOL_ENTRIES));
  assign fs_waddr   = PW'(free_count_q);

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    nonempty_d   = nonempty_q;
    free_count_d = free_count_q;
    low_d        = low_q;
    if (cmd_i.commit && op_push_ok_q) begin
      if (!nonempty_q[op_lvl_q]) begin
        head_d[op_lvl_q]     = alloc_e;
        nonempty_d[op_lvl_q] = 1'b1;
      end
      tail_d[op_lvl_q] = alloc_e;
      free_count_d     = free_count_q - CW'(1);
      if (op_fresh_q) begin
        low_d = free_count_q - CW'(1);
      end
    end else if (cmd_i.commit && op_pop_ok_q) begin
      if (op_last_q) begin
        head_d[op_lvl_q]     = '0;
        tail_d[op_lvl_q]     = '0;
        nonempty_d[op_lvl_q] = 1'b0;
      end else begin
        head_d[op_lvl_q] = link_rdata;
      end
      if (free_count_q < CW'(POOL_ENTRIES)) begin
        free_count_d = free_count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      nonempty_q   <= '0;
      free_count_q <= CW'(POOL_ENTRIES);
      low_q        <= CW'(POOL_ENTRIES);
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      nonempty_q   <= nonempty_d;
      free_count_q <= free_count_d;
      low_q        <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q       <= op_status_q;
      popped_level_q <= op_pop_ok_q ? 3'(op_lvl_q) : 3'd0;
      popped_tag_q   <= op_pop_ok_q ? 32'(tag_rdata) : 32'd0;
      pending_q      <= (nonempty_d != '0);
    end
  end

  sptq_ram #(.WIDTH(TW), .DEPTH(POOL_ENTRIES)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (alloc_e),
    .wdata_i (op_tag_q),
    .raddr_i (head_q[pop_lvl]),
    .rdata_o (tag_rdata)
  );

  sptq_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (alloc_e),
    .raddr_i (head_q[pop_lvl]),
    .rdata_o (link_rdata)
  );

  sptq_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (op_entry_q),
    .raddr_i (fs_top),
    .rdata_o (fs_rdata)
  );

  assign status_o        = status_q;
  assign popped_level_o  = popped_level_q;
  assign popped_tag_o    = popped_tag_q;
  assign tasks_pending_o = pending_q;

  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_q <= free_count_q) && (free_count_q <= CW'(POOL_ENTRIES)))
    else $error("free count out of order with low mark");

  a_empty_all_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nonempty_q == '0) |-> (free_count_q == CW'(POOL_ENTRIES)))
    else $error("all levels empty but entries missing from pool");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && op_pop_ok_q |=> free_count_q == $past(free_count_q) + CW'(1))
    else $error("pop did not return its entry");

endmodule

`default_nettype wire

[src/strict_priority_task_queue.sv]
`default_nettype none

// Channel   Handshake          Payload
// request   start / busy       func_i, priority_req_i, task_tag_i
// result    done_o (strobe)    status_o, popped_level_o, popped_tag_o, tasks_pending_o
//
// A request is taken when start is high and busy low. Its result shows one
// cycle with done_o once the request has passed the COMMIT state; a new one
// may be taken while done_o is high but not in COMMIT, set by the registered
// read of the tag/link and free stack memories ahead of the list update.
// Reset is asynchronous, active low; no memory clearing pass is needed.
// The receiver cannot stall; results are presented once.

module strict_priority_task_queue
  import sptq_pkg::*;
#(
  parameter int LEVELS       = 8,
  parameter int POOL_ENTRIES = 64,
  parameter int TAG_BITS     = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func_i,
  input  wire logic [2:0]  priority_req_i,
  input  wire logic [31:0] task_tag_i,
  output logic             done_o,
  output logic      [1:0]  status_o,
  output logic      [2:0]  popped_level_o,
  output logic      [31:0] popped_tag_o,
  output logic             tasks_pending_o
);

  ctrl_cmd_t cmd;

  sptq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  sptq_dp #(
    .LEVELS       (LEVELS),
    .POOL_ENTRIES (POOL_ENTRIES),
    .TAG_BITS     (TAG_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (func_i),
    .priority_req_i  (priority_req_i),
    .task_tag_i      (task_tag_i),
    .status_o        (status_o),
    .popped_level_o  (popped_level_o),
    .popped_tag_o    (popped_tag_o),
    .tasks_pending_o (tasks_pending_o)
  );

endmodule

`default_nettype wire
